/* sv/fsa_pkg.sv */
package fsa_pkg;

    // Pool geometry
    localparam int POOL_DEPTH = 512;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = IDX_W + 1;

    // Fixed field widths
    localparam int SLOT_W     = 10;
    localparam int FENCE_W    = 64;
    localparam int CFG_W      = 64;
    localparam int CFG_ADDR_W = 2;
    localparam int S_TDATA_W  = 144;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;

    localparam logic [FENCE_W-1:0] NO_FENCE_RESET = 64'h0000_0000_FFFF_FFFF;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_POOL_SIZE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NO_FENCE  = 2'd1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_DISCARD = 2'd1,
        OP_RECLAIM = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        DS_ACCEPTED = 2'd0,
        DS_RANGE    = 2'd1,
        DS_FREE     = 2'd2,
        DS_PENDING  = 2'd3
    } dstat_t;

    // Write/read requests to the slot stores
    typedef struct packed {
        logic               fs_we;
        logic [IDX_W-1:0]   fs_waddr;
        logic [IDX_W-1:0]   fs_wdata;
        logic [IDX_W-1:0]   fs_raddr;
        logic               ps_we;
        logic [IDX_W-1:0]   ps_waddr;
        logic [IDX_W-1:0]   ps_wslot;
        logic [FENCE_W-1:0] ps_wfence;
        logic [IDX_W-1:0]   ps_raddr;
    } mem_req_t;

    // Compare unit results
    typedef struct packed {
        logic slot_eq;
        logic fence_ready;
    } cmp_res_t;

endpackage

/* sv/fenced_slot_allocator.sv */
// Allocate pops the free stack top (straight to the result when no slot is free); discard
//   scans the free stack, then the pending list (straight to the result when out of range).
// Reclaim rechecks each pending entry and fills each reclaimed one with the last entry.
// Transactions are handled one at a time; s_tready returns as the result is presented, and
//   a result still held by m_tready stalls the sequencer before the next one is loaded.
// Reset (aresetn low, synchronous): 512 free slots, empty pending list, peak cleared;
module fenced_slot_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // slot_index[9:0], fence_value[73:10], completed_fence[137:74], zero pad
    input  logic [fsa_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode[1:0]
    input  logic [fsa_pkg::S_TUSER_W-1:0]   s_tuser,
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // alloc_ok[0], alloc_index[9:1], discard_status[11:10], reclaimed_count[21:12],
    // peak_in_use[31:22]
    output logic [fsa_pkg::M_TDATA_W-1:0]   m_tdata,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [fsa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fsa_pkg::CFG_W-1:0]       cfg_wdata
);
    import fsa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_AWAIT   = 9'b000000010,
        S_DSCAN_F = 9'b000000100,
        S_DSCAN_P = 9'b000001000,
        S_DDEC    = 9'b000010000,
        S_RREAD   = 9'b000100000,
        S_REVAL   = 9'b001000000,
        S_RMOVE   = 9'b010000000,
        S_OUT     = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   pool_reg, pool_next;
    logic [FENCE_W-1:0] marker_reg, marker_next;
    logic [CNT_W-1:0]   fc_reg, fc_next;
    logic [CNT_W-1:0]   pc_reg, pc_next;
    logic [CNT_W-1:0]   mark_reg, mark_next;
    logic [CNT_W-1:0]   peak_reg, peak_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               rv_reg, rv_next;
    logic               ffree_reg, ffree_next;
    logic               fpend_reg, fpend_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [FENCE_W-1:0] fence_reg, fence_next;
    logic [FENCE_W-1:0] done_reg, done_next;
    logic               ok_reg, ok_next;
    logic [IDX_W-1:0]   aidx_reg, aidx_next;
    dstat_t             stat_reg, stat_next;
    logic [CNT_W-1:0]   rcl_reg, rcl_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    opcode_t            in_op;
    logic [SLOT_W-1:0]  in_slot;
    logic [FENCE_W-1:0] in_fence;
    logic [FENCE_W-1:0] in_done;
    logic               in_acc;

    mem_req_t           req;
    logic [IDX_W-1:0]   fs_rdata;
    logic [IDX_W-1:0]   ps_rslot;
    logic [FENCE_W-1:0] ps_rfence;
    cmp_res_t           cmp;
    logic [IDX_W-1:0]   cmp_slot;

    logic [CNT_W-1:0]   fc_dec;
    logic [CNT_W-1:0]   pc_dec;
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   used;
    logic [CNT_W-1:0]   cfg_size;

    // Field unpacking
    assign in_op    = opcode_t'(s_tuser);
    assign in_slot  = s_tdata[SLOT_W-1:0];
    assign in_fence = s_tdata[SLOT_W+FENCE_W-1:SLOT_W];
    assign in_done  = s_tdata[SLOT_W+2*FENCE_W-1:SLOT_W+FENCE_W];
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign fc_dec  = fc_reg - 1'b1;
    assign pc_dec  = pc_reg - 1'b1;
    assign idx_inc = idx_reg + 1'b1;
    assign used    = (pool_reg >= fc_dec) ? (pool_reg - fc_dec) : '0;

    // Clamped pool size from a configuration write
    always_comb begin
        cfg_size = cfg_wdata[CNT_W-1:0];
        if (cfg_size == '0) begin
            cfg_size = CNT_W'(1);
        end else if (cfg_size > CNT_W'(POOL_DEPTH)) begin
            cfg_size = CNT_W'(POOL_DEPTH);
        end
    end

    // Slot stores
    fsa_mem u_mem (
        .aclk      (aclk),
        .req       (req),
        .fill_mark (mark_reg),
        .fs_rdata  (fs_rdata),
        .ps_rslot  (ps_rslot),
        .ps_rfence (ps_rfence)
    );

    // Shared compare unit
    assign cmp_slot = (state_reg == S_DSCAN_F) ? fs_rdata : ps_rslot;

    fsa_cmp u_cmp (
        .slot_a     (cmp_slot),
        .slot_b     (slot_reg),
        .fence      (ps_rfence),
        .done_fence (done_reg),
        .marker     (marker_reg),
        .res        (cmp)
    );

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        pool_next     = pool_reg;
        marker_next   = marker_reg;
        fc_next       = fc_reg;
        pc_next       = pc_reg;
        mark_next     = mark_reg;
        peak_next     = peak_reg;
        idx_next      = idx_reg;
        rv_next       = 1'b0;
        ffree_next    = ffree_reg;
        fpend_next    = fpend_reg;
        slot_next     = slot_reg;
        fence_next    = fence_reg;
        done_next     = done_reg;
        ok_next       = ok_reg;
        aidx_next     = aidx_reg;
        stat_next     = stat_reg;
        rcl_next      = rcl_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        req           = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    ok_next   = 1'b0;
                    aidx_next = '0;
                    stat_next = DS_ACCEPTED;
                    rcl_next  = '0;
                    unique case (in_op)
                        OP_ALLOC: begin
                            if (fc_reg == '0) begin
                                state_next = S_OUT;
                            end else begin
                                // pop from the top
                                req.fs_raddr = fc_dec[IDX_W-1:0];
                                fc_next      = fc_dec;
                                if (fc_dec < mark_reg) begin
                                    mark_next = fc_dec;
                                end
                                if (used > peak_reg) begin
                                    peak_next = used;
                                end
                                state_next = S_AWAIT;
                            end
                        end
                        OP_DISCARD: begin
                            if (in_slot >= pool_reg) begin
                                stat_next  = DS_RANGE;
                                state_next = S_OUT;
                            end else begin
                                slot_next  = in_slot[IDX_W-1:0];
                                fence_next = in_fence;
                                idx_next   = '0;
                                ffree_next = 1'b0;
                                fpend_next = 1'b0;
                                state_next = S_DSCAN_F;
                            end
                        end
                        OP_RECLAIM: begin
                            done_next  = in_done;
                            idx_next   = '0;
                            state_next = (pc_reg == '0) ? S_OUT : S_RREAD;
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_AWAIT: begin
                ok_next    = 1'b1;
                aidx_next  = fs_rdata;
                state_next = S_OUT;
            end
            S_DSCAN_F: begin
                // compare the entry read last cycle, issue the next one
                if (rv_reg && cmp.slot_eq) begin
                    ffree_next = 1'b1;
                end
                if (idx_reg < fc_reg) begin
                    req.fs_raddr = idx_reg[IDX_W-1:0];
                    idx_next     = idx_inc;
                    rv_next      = 1'b1;
                end else begin
                    idx_next   = '0;
                    state_next = S_DSCAN_P;
                end
            end
            S_DSCAN_P: begin
                if (rv_reg && cmp.slot_eq) begin
                    fpend_next = 1'b1;
                end
                if (idx_reg < pc_reg) begin
                    req.ps_raddr = idx_reg[IDX_W-1:0];
                    idx_next     = idx_inc;
                    rv_next      = 1'b1;
                end else begin
                    state_next = S_DDEC;
                end
            end
            S_DDEC: begin
                priority if (ffree_reg) begin
                    stat_next = DS_FREE;
                end else if (fpend_reg) begin
                    stat_next = DS_PENDING;
                end else if (pc_reg < CNT_W'(POOL_DEPTH)) begin
                    req.ps_we     = 1'b1;
                    req.ps_waddr  = pc_reg[IDX_W-1:0];
                    req.ps_wslot  = slot_reg;
                    req.ps_wfence = fence_reg;
                    pc_next       = pc_reg + 1'b1;
                    stat_next     = DS_ACCEPTED;
                end else begin
                    stat_next = DS_ACCEPTED;
                end
                state_next = S_OUT;
            end
            S_RREAD: begin
                req.ps_raddr = idx_reg[IDX_W-1:0];
                state_next   = S_REVAL;
            end
            S_REVAL: begin
                if (cmp.fence_ready) begin
                    // return the slot, then fetch the last entry to fill the hole
                    if (fc_reg < CNT_W'(POOL_DEPTH)) begin
                        req.fs_we    = 1'b1;
                        req.fs_waddr = fc_reg[IDX_W-1:0];
                        req.fs_wdata = ps_rslot;
                        fc_next      = fc_reg + 1'b1;
                    end
                    rcl_next     = rcl_reg + 1'b1;
                    req.ps_raddr = pc_dec[IDX_W-1:0];
                    state_next   = S_RMOVE;
                end else begin
                    idx_next = idx_inc;
                    if (idx_inc < pc_reg) begin
                        req.ps_raddr = idx_inc[IDX_W-1:0];
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_RMOVE: begin
                req.ps_we     = 1'b1;
                req.ps_waddr  = idx_reg[IDX_W-1:0];
                req.ps_wslot  = ps_rslot;
                req.ps_wfence = ps_rfence;
                pc_next       = pc_dec;
                state_next    = (idx_reg < pc_dec) ? S_RREAD : S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {peak_reg, rcl_reg, stat_reg, aidx_reg, ok_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration writes (the user must issue them only while idle; the block does not check)
        if (cfg_wr_en) begin
            if (cfg_addr == REG_POOL_SIZE) begin
                pool_next = cfg_size;
                fc_next   = cfg_size;
                mark_next = cfg_size;
                pc_next   = '0;
            end else if (cfg_addr == REG_NO_FENCE) begin
                marker_next = cfg_wdata[FENCE_W-1:0];
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pool_reg     <= CNT_W'(POOL_DEPTH);
            marker_reg   <= NO_FENCE_RESET;
            fc_reg       <= CNT_W'(POOL_DEPTH);
            pc_reg       <= '0;
            mark_reg     <= CNT_W'(POOL_DEPTH);
            peak_reg     <= '0;
            rv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pool_reg     <= pool_next;
            marker_reg   <= marker_next;
            fc_reg       <= fc_next;
            pc_reg       <= pc_next;
            mark_reg     <= mark_next;
            peak_reg     <= peak_next;
            rv_reg       <= rv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        ffree_reg   <= ffree_next;
        fpend_reg   <= fpend_next;
        slot_reg    <= slot_next;
        fence_reg   <= fence_next;
        done_reg    <= done_next;
        ok_reg      <= ok_next;
        aidx_reg    <= aidx_next;
        stat_reg    <= stat_next;
        rcl_reg     <= rcl_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Fill mark never sits above the stack top
    a_mark_le_top: assert property (@(posedge aclk) disable iff (!aresetn)
        mark_reg <= fc_reg)
        else $error("fill mark above free stack top");

    // An accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start");

    // Result hand-off loads the output register and returns to idle
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && (!m_tvalid || m_tready)) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("result not presented");

    // Peak usage never falls
    a_peak_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (peak_reg >= $past(peak_reg)))
        else $error("peak usage decreased");

endmodule

/* sv/fsa_mem.sv */
module fsa_mem (
    input  logic                         aclk,
    input  fsa_pkg::mem_req_t            req,
    input  logic [fsa_pkg::CNT_W-1:0]    fill_mark,
    output logic [fsa_pkg::IDX_W-1:0]    fs_rdata,
    output logic [fsa_pkg::IDX_W-1:0]    ps_rslot,
    output logic [fsa_pkg::FENCE_W-1:0]  ps_rfence
);
    import fsa_pkg::*;

    logic [IDX_W-1:0]   fs_mem [POOL_DEPTH];
    logic [IDX_W-1:0]   ps_slot_mem [POOL_DEPTH];
    logic [FENCE_W-1:0] ps_fence_mem [POOL_DEPTH];

    logic [IDX_W-1:0]   fs_data_reg;
    logic [IDX_W-1:0]   fs_addr_reg;
    logic               fs_low_reg;
    logic [IDX_W-1:0]   ps_slot_reg;
    logic [FENCE_W-1:0] ps_fence_reg;

    // Free stack: one write, one registered read
    always_ff @(posedge aclk) begin
        if (req.fs_we) begin
            fs_mem[req.fs_waddr] <= req.fs_wdata;
        end
        fs_data_reg <= fs_mem[req.fs_raddr];
        fs_addr_reg <= req.fs_raddr;
        fs_low_reg  <= ({1'b0, req.fs_raddr} < fill_mark);
    end

    // Pending list: one write, one registered read
    always_ff @(posedge aclk) begin
        if (req.ps_we) begin
            ps_slot_mem[req.ps_waddr]  <= req.ps_wslot;
            ps_fence_mem[req.ps_waddr] <= req.ps_wfence;
        end
        ps_slot_reg  <= ps_slot_mem[req.ps_raddr];
        ps_fence_reg <= ps_fence_mem[req.ps_raddr];
    end

    // Entries below the fill mark are untouched since refill and hold their own index
    assign fs_rdata  = fs_low_reg ? fs_addr_reg : fs_data_reg;
    assign ps_rslot  = ps_slot_reg;
    assign ps_rfence = ps_fence_reg;

endmodule

/* sv/fsa_cmp.sv */
module fsa_cmp (
    input  logic [fsa_pkg::IDX_W-1:0]   slot_a,
    input  logic [fsa_pkg::IDX_W-1:0]   slot_b,
    input  logic [fsa_pkg::FENCE_W-1:0] fence,
    input  logic [fsa_pkg::FENCE_W-1:0] done_fence,
    input  logic [fsa_pkg::FENCE_W-1:0] marker,
    output fsa_pkg::cmp_res_t           res
);
    import fsa_pkg::*;

    // Slot match for the discard scans; fence check for reclaim
    always_comb begin
        res.slot_eq     = (slot_a == slot_b);
        res.fence_ready = (fence == marker) || (done_fence >= fence);
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import fsa_pkg::*;

    // Spare register index: writes to it must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE    = 2'd3;
    localparam int                    SETTLE_TICKS = 16;

    // Reply fields, packed so that the struct matches m_tdata bit for bit
    typedef struct packed {
        logic [9:0] peak;
        logic [9:0] reclaimed;
        dstat_t     status;
        logic [8:0] slot;
        logic       granted;
    } slot_reply_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic [S_TUSER_W-1:0]    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_wr_en;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_W-1:0]        cfg_wdata;

    fenced_slot_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Allocator shadow state
    logic [8:0]  free_stack [POOL_DEPTH];
    int          free_cnt;
    logic [8:0]  pend_slot  [POOL_DEPTH];
    logic [63:0] pend_fence [POOL_DEPTH];
    int          pend_cnt;
    int          peak_used;
    int          pool_size;
    logic [63:0] no_fence;
    bit          held       [POOL_DEPTH];

    slot_reply_t replies_due[$];
    int          mismatch_count;
    bit          src_idle;
    bit          snk_idle;
    logic [63:0] fence_clock;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // When enabled, roughly half the transactions go without a gap, the rest wait a random gap
    function automatic int draw_gap(input bit enabled);
        if (!enabled)
            return 0;
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return $urandom_range(1, 3);
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    // Pool refill: free stack holds 0..pool_size-1, top last; pending list emptied
    function automatic void refill_pool();
        for (int k = 0; k < POOL_DEPTH; k++) begin
            free_stack[k] = 9'(k);
            held[k]       = 1'b0;
        end
        free_cnt = pool_size;
        pend_cnt = 0;
    endfunction

    // Shadow allocator: applies one command and returns the reply it produces
    function automatic slot_reply_t predict_reply(input opcode_t op, input logic [9:0] slot,
                                                  input logic [63:0] fence,
                                                  input logic [63:0] done);
        slot_reply_t r;
        bit          hit;
        int          k;
        int          returned;
        r        = '0;
        hit      = 1'b0;
        returned = 0;
        case (op)
            OP_ALLOC: begin
                if (free_cnt > 0) begin
                    free_cnt--;
                    r.slot        = free_stack[free_cnt];
                    r.granted     = 1'b1;
                    held[r.slot]  = 1'b1;
                    if (pool_size - free_cnt > peak_used)
                        peak_used = pool_size - free_cnt;
                end
            end
            OP_DISCARD: begin
                if (slot >= pool_size) begin
                    r.status = DS_RANGE;
                end else begin
                    for (k = 0; k < free_cnt; k++)
                        if (free_stack[k] == slot[8:0]) hit = 1'b1;
                    if (hit) begin
                        r.status = DS_FREE;
                    end else begin
                        for (k = 0; k < pend_cnt; k++)
                            if (pend_slot[k] == slot[8:0]) hit = 1'b1;
                        if (hit) begin
                            r.status = DS_PENDING;
                        end else if (pend_cnt < POOL_DEPTH) begin
                            pend_slot[pend_cnt]  = slot[8:0];
                            pend_fence[pend_cnt] = fence;
                            pend_cnt++;
                            held[slot[8:0]] = 1'b0;
                        end
                    end
                end
            end
            OP_RECLAIM: begin
                // Reclaimed entry is replaced by the last one, which is then checked in place
                k = 0;
                while (k < pend_cnt) begin
                    if (pend_fence[k] != no_fence && done < pend_fence[k]) begin
                        k++;
                    end else begin
                        if (free_cnt < POOL_DEPTH) begin
                            free_stack[free_cnt] = pend_slot[k];
                            free_cnt++;
                        end
                        pend_slot[k]  = pend_slot[pend_cnt - 1];
                        pend_fence[k] = pend_fence[pend_cnt - 1];
                        pend_cnt--;
                        returned++;
                    end
                end
                r.reclaimed = 10'(returned);
            end
            default: ;
        endcase
        r.peak = 10'(peak_used);
        return r;
    endfunction

    // Send one command; s_tvalid is left high so a back-to-back transaction follows cleanly
    task automatic send_item(input opcode_t op, input logic [9:0] slot,
                             input logic [63:0] fence, input logic [63:0] done);
        int gap;
        gap = draw_gap(src_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        // upper 6 bits are padding
        s_tdata  <= {6'b0, done, fence, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        replies_due.push_back(predict_reply(op, slot, fence, done));
    endtask

    // Stop sending and wait for every outstanding reply
    task automatic drain();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // Register write, only issued while the block is idle
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == REG_POOL_SIZE) begin
            if (value[9:0] == 10'd0)
                pool_size = 1;
            else if (value[9:0] > POOL_DEPTH)
                pool_size = POOL_DEPTH;
            else
                pool_size = int'(value[9:0]);
            refill_pool();
        end else if (addr == REG_NO_FENCE) begin
            no_fence = value;
        end
        @(posedge aclk);
    endtask

    // Mostly well-formed traffic: discards aim at held slots, fences track a moving clock
    task automatic random_traffic(input int n, input int w_alloc, input int w_discard,
                                  input int w_reclaim);
        opcode_t     op;
        logic [9:0]  slot;
        logic [63:0] fence;
        logic [63:0] done;
        int          roll;
        int          pick;
        int          owned[$];
        repeat (n) begin
            op    = OP_NONE;
            slot  = 10'($urandom_range(0, 1023));
            fence = rand64();
            done  = rand64();
            roll  = $urandom_range(0, w_alloc + w_discard + w_reclaim + 3);
            if (roll < w_alloc) begin
                op = OP_ALLOC;
            end else if (roll < w_alloc + w_discard) begin
                op = OP_DISCARD;
                owned.delete();
                for (int s = 0; s < pool_size; s++)
                    if (held[s]) owned.push_back(s);
                pick = $urandom_range(0, 99);
                if (pick < 70 && owned.size() > 0)
                    slot = 10'(owned[$urandom_range(0, owned.size() - 1)]);
                else if (pick < 80 && pend_cnt > 0)
                    slot = {1'b0, pend_slot[$urandom_range(0, pend_cnt - 1)]};
                else if (pick < 88 && free_cnt > 0)
                    slot = {1'b0, free_stack[$urandom_range(0, free_cnt - 1)]};
                else if (pick < 94)
                    slot = 10'($urandom_range(pool_size, 1023));
                case ($urandom_range(0, 9))
                    0:       fence = no_fence;
                    1:       fence = rand64();
                    2:       fence = '1;
                    default: fence = fence_clock + $urandom_range(0, 12);
                endcase
            end else if (roll < w_alloc + w_discard + w_reclaim) begin
                op = OP_RECLAIM;
                case ($urandom_range(0, 9))
                    0:       done = rand64();
                    1:       done = '1;
                    2:       done = fence_clock - 1;
                    default: begin
                        done        = fence_clock + $urandom_range(0, 6);
                        fence_clock = fence_clock + $urandom_range(0, 4);
                    end
                endcase
            end
            send_item(op, slot, fence, done);
        end
    endtask

    // Field extremes, every opcode, clamping of the pool size, swap-and-recheck on reclaim
    task automatic test_directed_cases();
        send_item(OP_ALLOC,   10'd0,    '0, '0);
        send_item(OP_DISCARD, 10'd1023, '1, '0);
        send_item(OP_DISCARD, 10'd0,    '0, '0);
        send_item(OP_DISCARD, 10'd511,  '1, '0);
        send_item(OP_DISCARD, 10'd511,  '0, '0);
        send_item(OP_RECLAIM, 10'd0,    '0, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(OP_RECLAIM, 10'd0,    '0, '1);
        send_item(OP_NONE,    10'd1023, '1, '1);
        send_item(OP_ALLOC,   10'd0,    '0, '0);
        send_item(OP_DISCARD, 10'd511,  NO_FENCE_RESET, '0);
        send_item(OP_RECLAIM, 10'd0,    '0, '0);
        drain();

        // zero pool size clamps to one slot
        cfg_write(REG_POOL_SIZE, 64'd0);
        cfg_write(REG_SPARE, '1);
        send_item(OP_ALLOC,   10'd0, '0, '0);
        send_item(OP_ALLOC,   10'd0, '0, '0);
        send_item(OP_DISCARD, 10'd1, '0, '0);
        send_item(OP_DISCARD, 10'd0, 64'd7, '0);
        send_item(OP_RECLAIM, 10'd0, '0, 64'd6);
        send_item(OP_RECLAIM, 10'd0, '0, 64'd7);
        drain();

        // oversize pool clamps to full depth
        cfg_write(REG_POOL_SIZE, 64'd1023);
        send_item(OP_ALLOC,   10'd0,   '0, '0);
        send_item(OP_DISCARD, 10'd600, '0, '0);
        drain();

        // marker of zero; the moved-in entry is rechecked and kept
        cfg_write(REG_NO_FENCE, 64'd0);
        cfg_write(REG_POOL_SIZE, 64'd3);
        repeat (3) send_item(OP_ALLOC, 10'd0, '0, '0);
        send_item(OP_DISCARD, 10'd1, 64'd5, '0);
        send_item(OP_DISCARD, 10'd2, 64'd0, '0);
        send_item(OP_DISCARD, 10'd0, 64'd9, '0);
        send_item(OP_RECLAIM, 10'd0, '0, 64'd4);
        send_item(OP_RECLAIM, 10'd0, '0, '1);
        drain();
    endtask

    task automatic test_small_pool();
        cfg_write(REG_NO_FENCE, 64'd100);
        cfg_write(REG_POOL_SIZE, 64'd8);
        fence_clock = 64'd90;
        random_traffic(220, 40, 35, 21);
        drain();
    endtask

    task automatic test_single_slot_pool();
        cfg_write(REG_POOL_SIZE, 64'd1);
        random_traffic(60, 35, 35, 26);
        drain();
    endtask

    // Fences drawn across a random marker, then an all-ones marker
    task automatic test_marker_changes();
        cfg_write(REG_NO_FENCE, rand64());
        cfg_write(REG_POOL_SIZE, 64'd40);
        fence_clock = no_fence - 20;
        random_traffic(100, 40, 35, 21);
        drain();
        cfg_write(REG_NO_FENCE, '1);
        random_traffic(100, 40, 35, 21);
        drain();
    endtask

    task automatic test_back_to_back();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        cfg_write(REG_NO_FENCE, NO_FENCE_RESET);
        cfg_write(REG_POOL_SIZE, 64'd24);
        fence_clock = 64'hFFFF_FFF0;
        random_traffic(120, 40, 35, 21);
        drain();
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    // Whole pool handed out, peak reaches full depth, then a mixed tail
    task automatic test_full_pool();
        cfg_write(REG_POOL_SIZE, 64'hDEAD_0000_0000_0200);
        fence_clock = 64'hFFFF_FFFF_FFFF_FF00;
        src_idle = 1'b0;
        while (free_cnt > 0)
            send_item(OP_ALLOC, 10'($urandom_range(0, 1023)), rand64(), rand64());
        send_item(OP_ALLOC, 10'($urandom_range(0, 1023)), rand64(), rand64());
        src_idle = 1'b1;
        random_traffic(50, 20, 50, 30);
        drain();
    endtask

    // Stimulus and verdict
    initial begin
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= OP_NONE;
        cfg_wr_en      <= 1'b0;
        cfg_addr       <= REG_POOL_SIZE;
        cfg_wdata      <= '0;
        aresetn        <= 1'b0;
        mismatch_count = 0;
        src_idle       = 1'b1;
        snk_idle       = 1'b1;
        fence_clock    = 64'd0;
        pool_size      = POOL_DEPTH;
        no_fence       = NO_FENCE_RESET;
        peak_used      = 0;
        refill_pool();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_small_pool();
        test_single_slot_pool();
        test_marker_changes();
        test_back_to_back();
        test_full_pool();

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Result side back-pressure
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap(snk_idle);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Reply checker: each result transaction against the oldest expectation
    always @(posedge aclk) begin
        slot_reply_t got;
        slot_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = slot_reply_t'(m_tdata);
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected reply, expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = replies_due.pop_front();
                compare_field("alloc_ok",        want.granted,   got.granted);
                compare_field("alloc_index",     want.slot,      got.slot);
                compare_field("discard_status",  want.status,    got.status);
                compare_field("reclaimed_count", want.reclaimed, got.reclaimed);
                compare_field("peak_in_use",     want.peak,      got.peak);
            end
        end
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
sv/fsa_pkg.sv
sv/fsa_mem.sv
sv/fsa_cmp.sv
sv/fenced_slot_allocator.sv
tb/testbench.sv
